// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define TBPF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: label");

// Checks that a condition never holds at a rising clock edge outside reset.
`define TBPF_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen: label");

`else

`define TBPF_ASSERT(label, clk, rst, prop)
`define TBPF_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/core/tbpf_pkg.sv =====
`default_nettype none
package tbpf_pkg;

  localparam int VRAM_HALFWORDS  = 32768;
  localparam int VRAM_AW         = $clog2(VRAM_HALFWORDS);
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

  typedef enum logic [1:0] {
    CMD_RENDER     = 2'd0,
    CMD_WRITE_VRAM = 2'd1,
    CMD_WRITE_PAL  = 2'd2
  } cmd_t;

  localparam logic [2:0] REG_LAYER_ENABLE = 3'd0;
  localparam logic [2:0] REG_MAP_BASE     = 3'd1;
  localparam logic [2:0] REG_PATTERN_BASE = 3'd2;
  localparam logic [2:0] REG_SCREEN_SIZE  = 3'd3;
  localparam logic [2:0] REG_COLOR_MODE   = 3'd4;
  localparam logic [2:0] REG_HSCROLL      = 3'd5;
  localparam logic [2:0] REG_VSCROLL      = 3'd6;

  localparam logic [1:0] SIZE_ONE  = 2'd0;
  localparam logic [1:0] SIZE_WIDE = 2'd1;
  localparam logic [1:0] SIZE_TALL = 2'd2;
  localparam logic [1:0] SIZE_QUAD = 2'd3;

  typedef struct packed {
    logic       layer_enable;
    logic [4:0] map_base;
    logic [1:0] pattern_base;
    logic [1:0] screen_size;
    logic       color_mode;
    logic [8:0] hscroll;
    logic [8:0] vscroll;
  } cfg_t;

  function automatic logic [1:0] quad_block(input logic [1:0] size, input logic qy,
                                            input logic qx);
    unique case (size)
      SIZE_ONE:  return 2'd0;
      SIZE_WIDE: return {1'b0, qx};
      SIZE_TALL: return {1'b0, qy};
      SIZE_QUAD: return {qy, qx};
      default:   return 2'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tbpf_ram.sv =====
`default_nettype none
module tbpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tbpf_pixel_pipe.sv =====
`default_nettype none
module tbpf_pixel_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tbpf_pkg::cfg_t                cfg,
  input  wire logic                          adv,
  input  wire logic                          in_fire,
  input  wire logic [1:0]                    command,
  input  wire logic [14:0]                   address,
  input  wire logic [15:0]                   data,
  input  wire logic [7:0]                    line,
  input  wire logic [7:0]                    column,
  input  wire logic [15:0]                   map_rdata,
  input  wire logic [15:0]                   tile_rdata,
  output logic                               vram_we,
  output logic [tbpf_pkg::VRAM_AW-1:0]       vram_waddr,
  output logic [15:0]                        vram_wdata,
  output logic [tbpf_pkg::VRAM_AW-1:0]       map_raddr,
  output logic [tbpf_pkg::VRAM_AW-1:0]       tile_raddr,
  output logic                               pal_we,
  output logic [tbpf_pkg::PAL_AW-1:0]        pal_waddr,
  output logic [15:0]                        pal_wdata,
  output logic [tbpf_pkg::PAL_AW-1:0]        pal_raddr,
  output logic                               s3_render,
  output logic                               s3_transparent
);
  import tbpf_pkg::*;

  logic [8:0]  py;
  logic [8:0]  px;
  logic [1:0]  block;
  logic [14:0] map_half;

  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic [PAL_AW-1:0] s1_paddr;
  logic [15:0]       s1_data;
  logic [2:0]        s1_fy;
  logic [2:0]        s1_fx;

  logic [2:0]  row;
  logic [2:0]  k;
  logic [15:0] tile_byte;

  logic              s2_valid;
  logic [1:0]        s2_cmd;
  logic [PAL_AW-1:0] s2_paddr;
  logic [15:0]       s2_data;
  logic              s2_byte_sel;
  logic              s2_nib_sel;
  logic [3:0]        s2_bank;

  logic [7:0] tile_b;
  logic [3:0] nibble;
  logic [7:0] idx;

  always_comb begin
    py       = {1'b0, line} + cfg.vscroll;
    px       = {1'b0, column} + cfg.hscroll;
    block    = quad_block(cfg.screen_size, py[8], px[8]);
    map_half = {cfg.map_base + {3'b000, block}, py[7:3], px[7:3]};
  end

  assign map_raddr  = map_half[VRAM_AW-1:0];
  assign vram_we    = in_fire && (command == CMD_WRITE_VRAM);
  assign vram_waddr = address[VRAM_AW-1:0];
  assign vram_wdata = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd   <= command;
      s1_paddr <= address[PAL_AW-1:0];
      s1_data  <= data;
      s1_fy    <= py[2:0];
      s1_fx    <= px[2:0];
    end
  end

  always_comb begin
    row = map_rdata[11] ? ~s1_fy : s1_fy;
    k   = map_rdata[10] ? ~s1_fx : s1_fx;
    if (cfg.color_mode) begin
      tile_byte = {cfg.pattern_base, 14'd0} + {map_rdata[9:0], row, k};
    end else begin
      tile_byte = {cfg.pattern_base, 14'd0} + {1'b0, map_rdata[9:0], row, k[2:1]};
    end
  end

  assign tile_raddr = tile_byte[VRAM_AW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd      <= s1_cmd;
      s2_paddr    <= s1_paddr;
      s2_data     <= s1_data;
      s2_byte_sel <= tile_byte[0];
      s2_nib_sel  <= k[0];
      s2_bank     <= map_rdata[15:12];
    end
  end

  always_comb begin
    tile_b = s2_byte_sel ? tile_rdata[15:8] : tile_rdata[7:0];
    nibble = s2_nib_sel ? tile_b[7:4] : tile_b[3:0];
    if (cfg.color_mode) begin
      idx = tile_b;
    end else if (nibble == 4'd0) begin
      idx = 8'd0;
    end else begin
      idx = {s2_bank, nibble};
    end
  end

  assign pal_raddr = idx[PAL_AW-1:0];
  assign pal_we    = adv && s2_valid && (s2_cmd == CMD_WRITE_PAL);
  assign pal_waddr = s2_paddr;
  assign pal_wdata = s2_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_render <= 1'b0;
    end else if (adv) begin
      s3_render <= s2_valid && (s2_cmd == CMD_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_transparent <= !cfg.layer_enable || (idx == 8'd0);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tiled_background_pixel_fetch.sv =====
// Renders one pixel of a scrolled tile-map background per cycle. Video memory and the
// palette are loaded through the same input channel by write beats; a render beat
// returns one result beat from an output register, and other beats return none. The
// block takes one beat every cycle unless stalled: the map read, the tile read and the
// palette read each sit in their own pipeline stage, with video memory held as two
// identical copies so that map and tile reads of neighboring beats share a cycle.
// Palette writes are applied in the palette-read stage so that reads and writes keep
// beat order. The pipeline stalls only while a result waits at the output and another
// is ready behind it. Write configuration registers only while no beat is in flight.
`default_nettype none
`include "assert_macros.svh"
module tiled_background_pixel_fetch (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [14:0] address,
  input  wire logic [15:0] data,
  input  wire logic [7:0]  line,
  input  wire logic [7:0]  column,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      color,
  output logic             transparent
);
  import tbpf_pkg::*;

  cfg_t cfg;

  logic               adv;
  logic               in_fire;
  logic               vram_we;
  logic [VRAM_AW-1:0] vram_waddr;
  logic [15:0]        vram_wdata;
  logic [VRAM_AW-1:0] map_raddr;
  logic [VRAM_AW-1:0] tile_raddr;
  logic [15:0]        map_rdata;
  logic [15:0]        tile_rdata;
  logic               pal_we;
  logic [PAL_AW-1:0]  pal_waddr;
  logic [15:0]        pal_wdata;
  logic [PAL_AW-1:0]  pal_raddr;
  logic [15:0]        pal_rdata;
  logic               s3_render;
  logic               s3_transparent;
  logic               out_transparent;
  logic [14:0]        out_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LAYER_ENABLE: cfg.layer_enable <= cfg_data[0];
        REG_MAP_BASE:     cfg.map_base     <= cfg_data[4:0];
        REG_PATTERN_BASE: cfg.pattern_base <= cfg_data[1:0];
        REG_SCREEN_SIZE:  cfg.screen_size  <= cfg_data[1:0];
        REG_COLOR_MODE:   cfg.color_mode   <= cfg_data[0];
        REG_HSCROLL:      cfg.hscroll      <= cfg_data;
        REG_VSCROLL:      cfg.vscroll      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready || !s3_render;
  assign in_ready = adv;
  assign in_fire  = in_valid && adv;

  tbpf_pixel_pipe u_pipe (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .adv            (adv),
    .in_fire        (in_fire),
    .command        (command),
    .address        (address),
    .data           (data),
    .line           (line),
    .column         (column),
    .map_rdata      (map_rdata),
    .tile_rdata     (tile_rdata),
    .vram_we        (vram_we),
    .vram_waddr     (vram_waddr),
    .vram_wdata     (vram_wdata),
    .map_raddr      (map_raddr),
    .tile_raddr     (tile_raddr),
    .pal_we         (pal_we),
    .pal_waddr      (pal_waddr),
    .pal_wdata      (pal_wdata),
    .pal_raddr      (pal_raddr),
    .s3_render      (s3_render),
    .s3_transparent (s3_transparent)
  );

  tbpf_ram #(.WIDTH(16), .DEPTH(VRAM_HALFWORDS)) u_vram_map (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (adv),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  tbpf_ram #(.WIDTH(16), .DEPTH(VRAM_HALFWORDS)) u_vram_tile (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (adv),
    .raddr (tile_raddr),
    .rdata (tile_rdata)
  );

  tbpf_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (adv),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s3_render) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_render) begin
      out_transparent <= s3_transparent;
      out_color       <= s3_transparent ? 15'd0 : pal_rdata[14:0];
    end
  end

  assign color       = out_color;
  assign transparent = out_transparent;

  `TBPF_ASSERT(a_stall_only_when_blocked, clk, rst, !in_ready |-> out_valid && !out_ready)
  `TBPF_ASSERT(a_transparent_is_black, clk, rst, out_valid && transparent |-> color == 15'd0)
  `TBPF_ASSERT(a_result_from_advance, clk, rst, $rose(out_valid) |-> $past(in_ready))
  `TBPF_ASSERT_NEVER(a_no_write_in_stall, clk, rst, (vram_we || pal_we) && !adv)

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tbpf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1500;
  localparam int PHASES = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [14:0] color;
    logic        transparent;
  } pixel_t;

  class pixel_scoreboard;
    bit [15:0] vram [VRAM_HALFWORDS];
    bit        vram_written [VRAM_HALFWORDS];
    bit [15:0] palette [PALETTE_ENTRIES];
    bit        palette_written [PALETTE_ENTRIES];
    cfg_t      cfg = '0;
    pixel_t    pending_pixels [$];
    int        errors;

    function void set_reg(logic [2:0] idx, logic [8:0] v);
      case (idx)
        REG_LAYER_ENABLE: cfg.layer_enable = v[0];
        REG_MAP_BASE:     cfg.map_base = v[4:0];
        REG_PATTERN_BASE: cfg.pattern_base = v[1:0];
        REG_SCREEN_SIZE:  cfg.screen_size = v[1:0];
        REG_COLOR_MODE:   cfg.color_mode = v[0];
        REG_HSCROLL:      cfg.hscroll = v;
        REG_VSCROLL:      cfg.vscroll = v;
        default: ;
      endcase
    endfunction

    // Finds the map halfword and the tile halfword that a pixel reads.
    function void locate(input logic [7:0] ln, input logic [7:0] col,
                         output logic [14:0] map_half, output logic [14:0] tile_half,
                         output logic odd_byte, output logic high_nibble);
      logic [8:0]  py;
      logic [8:0]  px;
      logic [1:0]  blk;
      logic [15:0] entry;
      logic [2:0]  row;
      logic [2:0]  k;
      int          byte_addr;
      py = {1'b0, ln} + cfg.vscroll;
      px = {1'b0, col} + cfg.hscroll;
      case (cfg.screen_size)
        SIZE_WIDE: blk = {1'b0, px[8]};
        SIZE_TALL: blk = {1'b0, py[8]};
        SIZE_QUAD: blk = {py[8], px[8]};
        default:   blk = 2'd0;
      endcase
      byte_addr = cfg.map_base * 'h800 + blk * 'h800 + py[7:3] * 64 + px[7:3] * 2;
      map_half = byte_addr[15:1];
      entry = vram[map_half];
      row = entry[11] ? ~py[2:0] : py[2:0];
      k = entry[10] ? ~px[2:0] : px[2:0];
      if (cfg.color_mode)
        byte_addr = cfg.pattern_base * 'h4000 + entry[9:0] * 64 + row * 8 + k;
      else
        byte_addr = cfg.pattern_base * 'h4000 + entry[9:0] * 32 + row * 4 + k[2:1];
      tile_half = byte_addr[15:1];
      odd_byte = byte_addr[0];
      high_nibble = k[0];
    endfunction

    function logic [7:0] pixel_index(logic [7:0] ln, logic [7:0] col);
      logic [14:0] mh;
      logic [14:0] th;
      logic        odd;
      logic        hi;
      logic [7:0]  pix;
      logic [3:0]  nib;
      locate(ln, col, mh, th, odd, hi);
      pix = odd ? vram[th][15:8] : vram[th][7:0];
      if (cfg.color_mode)
        return pix;
      nib = hi ? pix[7:4] : pix[3:0];
      if (nib == 4'd0)
        return 8'd0;
      return {vram[mh][15:12], nib};
    endfunction

    function void note_beat(logic [1:0] cmd, logic [14:0] addr, logic [15:0] wdata,
                            logic [7:0] ln, logic [7:0] col);
      logic [7:0] idx;
      pixel_t     want;
      case (cmd)
        CMD_WRITE_VRAM: begin
          vram[addr] = wdata;
          vram_written[addr] = 1'b1;
        end
        CMD_WRITE_PAL: begin
          palette[addr[7:0]] = wdata;
          palette_written[addr[7:0]] = 1'b1;
        end
        CMD_RENDER: begin
          want.color = '0;
          want.transparent = 1'b1;
          if (cfg.layer_enable) begin
            idx = pixel_index(ln, col);
            if (idx != 8'd0) begin
              want.color = palette[idx][14:0];
              want.transparent = 1'b0;
            end
          end
          pending_pixels.push_back(want);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [14:0] got_color, logic got_transparent);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("result beat with nothing expected: color %h transparent %b",
                         got_color, got_transparent));
        return;
      end
      want = pending_pixels.pop_front();
      if (got_color !== want.color)
        report($sformatf("color %h, expected %h", got_color, want.color));
      if (got_transparent !== want.transparent)
        report($sformatf("transparent %b, expected %b", got_transparent, want.transparent));
    endtask

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_RENDER;
  logic [14:0] address = '0;
  logic [15:0] data = '0;
  logic [7:0]  line = '0;
  logic [7:0]  column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] color;
  logic        transparent;

  pixel_scoreboard sb = new;

  int ready_hold = 0;
  int ready_run = 0;
  int ready_roll;
  int quiet_cycles = 0;
  int send_run = 0;
  int beats_sent = 0;

  tiled_background_pixel_fetch dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .address     (address),
    .data        (data),
    .line        (line),
    .column      (column),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color       (color),
    .transparent (transparent)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 3) begin
        ready_run <= $urandom_range(50, 300);
        out_ready <= 1'b1;
      end else if (ready_roll < 8) begin
        ready_hold <= $urandom_range(5, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= (ready_roll >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(color, transparent);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tiled_background_pixel_fetch regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (send_run > 0) begin
      send_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_run = $urandom_range(50, 200);
      return 0;
    end
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_beat(logic [1:0] cmd, logic [14:0] addr, logic [15:0] wdata,
                           logic [7:0] ln, logic [7:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    address <= addr;
    data <= wdata;
    line <= ln;
    column <= col;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(cmd, addr, wdata, ln, col);
    beats_sent++;
  endtask

  // Loads every memory entry that the pixel will read and that holds nothing yet.
  task automatic prepare_pixel(logic [7:0] ln, logic [7:0] col);
    logic [14:0] mh;
    logic [14:0] th;
    logic        odd;
    logic        hi;
    logic [7:0]  idx;
    sb.locate(ln, col, mh, th, odd, hi);
    while (!sb.vram_written[mh] || !sb.vram_written[th]) begin
      send_beat(CMD_WRITE_VRAM, sb.vram_written[mh] ? th : mh, 16'($urandom),
                8'($urandom), 8'($urandom));
      sb.locate(ln, col, mh, th, odd, hi);
    end
    idx = sb.pixel_index(ln, col);
    if (!sb.palette_written[idx])
      send_beat(CMD_WRITE_PAL, {7'($urandom), idx}, 16'($urandom), 8'($urandom),
                8'($urandom));
  endtask

  task automatic render_at(logic [7:0] ln, logic [7:0] col, bit zero_tile);
    logic [14:0] mh;
    logic [14:0] th;
    logic        odd;
    logic        hi;
    prepare_pixel(ln, col);
    if (zero_tile) begin
      sb.locate(ln, col, mh, th, odd, hi);
      send_beat(CMD_WRITE_VRAM, th, 16'h0000, 8'($urandom), 8'($urandom));
      prepare_pixel(ln, col);
    end
    send_beat(CMD_RENDER, 15'($urandom), 16'($urandom), ln, col);
  endtask

  task automatic pause_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [8:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Unused upper data bits carry random values; the block must ignore them.
  task automatic apply_config(cfg_t c);
    put_reg(REG_LAYER_ENABLE, {8'($urandom), c.layer_enable});
    put_reg(REG_MAP_BASE, {4'($urandom), c.map_base});
    put_reg(REG_PATTERN_BASE, {7'($urandom), c.pattern_base});
    put_reg(REG_SCREEN_SIZE, {7'($urandom), c.screen_size});
    put_reg(REG_COLOR_MODE, {8'($urandom), c.color_mode});
    put_reg(REG_HSCROLL, c.hscroll);
    put_reg(REG_VSCROLL, c.vscroll);
    cfg_write <= 1'b0;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.layer_enable = ($urandom_range(0, 9) != 0);
    c.map_base = 5'($urandom);
    c.pattern_base = 2'($urandom);
    c.screen_size = 2'($urandom);
    c.color_mode = 1'($urandom);
    c.hscroll = 9'($urandom);
    c.vscroll = 9'($urandom);
    return c;
  endfunction

  task automatic random_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)
      render_at(8'($urandom), 8'($urandom), 1'b0);
    else if (r < 82)
      send_beat(CMD_WRITE_VRAM, 15'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 93)
      send_beat(CMD_WRITE_PAL, 15'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 96)
      send_beat(CMD_UNUSED, 15'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 97)
      pause_for_results();
    else
      render_at(8'($urandom), 8'($urandom), 1'b1);
  endtask

  initial begin
    int phase_end;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Layer disabled after reset, then the unused command and write address wrap.
    render_at(8'd0, 8'd0, 1'b0);
    send_beat(CMD_UNUSED, 15'h7fff, 16'hffff, 8'hff, 8'hff);
    send_beat(CMD_WRITE_PAL, 15'h7fff, 16'hffff, 8'h00, 8'h00);
    send_beat(CMD_WRITE_VRAM, 15'h0000, 16'h0000, 8'h00, 8'h00);
    settle();

    // Highest settings make the map and tile addresses wrap around video memory.
    apply_config(cfg_t'{layer_enable: 1'b1, map_base: 5'd31, pattern_base: 2'd3,
                        screen_size: SIZE_QUAD, color_mode: 1'b1,
                        hscroll: 9'd511, vscroll: 9'd511});
    render_at(8'd0, 8'd0, 1'b0);
    render_at(8'd255, 8'd255, 1'b0);
    render_at(8'd0, 8'd255, 1'b0);
    render_at(8'd255, 8'd0, 1'b0);
    render_at(8'd16, 8'd32, 1'b1);
    settle();

    apply_config(cfg_t'{layer_enable: 1'b1, map_base: 5'd0, pattern_base: 2'd0,
                        screen_size: SIZE_ONE, color_mode: 1'b0,
                        hscroll: 9'd0, vscroll: 9'd0});
    render_at(8'd0, 8'd0, 1'b0);
    render_at(8'd255, 8'd255, 1'b1);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      apply_config(random_config());
      phase_end = beats_sent + RANDOM_BEATS / PHASES;
      while (beats_sent < phase_end)
        random_beat();
      settle();
    end

    if (sb.errors == 0)
      $display("tiled_background_pixel_fetch regression: pass");
    else
      $display("tiled_background_pixel_fetch regression: fail");
    $finish;
  end
endmodule
